// ----- rtl/core/dqle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqle_pkg
// Shared types and constants for the DNS query-name label encoder.
// ----------------------------------------------------------------------------
package dqle_pkg;

  // longest label kept; longer labels are cut and flagged
  localparam int LABEL_MAX = 32;
  // label count must hold LABEL_MAX itself
  localparam int CNT_W     = $clog2(LABEL_MAX + 1);
  // label store index
  localparam int IDX_W     = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHARS,
    ST_TERM
  } state_t;

  // output byte source
  typedef enum logic [1:0] {
    OSEL_LEN,
    OSEL_CHAR,
    OSEL_TERM
  } osel_t;

  // controller to datapath
  typedef struct packed {
    logic  wr_char;
    logic  set_trunc;
    logic  clr_trunc;
    logic  clr_count;
    logic  ld_eon;
    logic  rd_rst;
    logic  rd_adv;
    logic  load_out;
    osel_t out_sel;
    logic  out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_eon;
    logic in_dot;
    logic count_zero;
    logic count_full;
    logic eon_flag;
    logic rd_at_end;
    logic slot_free;
  } stat_t;

endpackage

// ----- rtl/core/dns_qname_label_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_qname_label_encoder
// Turns a dotted host name, one character per beat, into DNS QNAME wire
// bytes: length-prefixed labels and a zero terminator.
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    ch, end_of_name
// out      output     out_valid/out_ready  out_byte, last, name_end,
//                                          label_truncated
//
// an ordinary character, or a dot with no label held, is taken without leaving idle
// a dot or end of name with bytes to emit is accepted, then the length byte, the
// characters and, at end of name, the terminator go out one by one, paced by the
// single output register
// in_ready is low during a flush; out_ready low stalls the flush in place
// reset clears count and flags; the label store needs no clearing
// ----------------------------------------------------------------------------
module dns_qname_label_encoder
  import dqle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       name_end,
  output logic       label_truncated
);

  cmd_t   cmd;
  stat_t  stat;
  state_t state;

  // sequencer
  dqle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  // store and output register
  dqle_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ch              (ch),
    .end_of_name     (end_of_name),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last            (last),
    .name_end        (name_end),
    .label_truncated (label_truncated)
  );

`ifndef ASSERT_OFF
  // terminator always closes the beats of its input
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && name_end |-> last)
    else $error("terminator beat without last");

  // truncation flag only rides on the terminator
  a_trunc_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && label_truncated |-> name_end)
    else $error("truncation flag on a non-terminator beat");

  // a flush of a held label blocks the input on the next cycle
  a_flush_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (end_of_name || stat.in_dot) && !stat.count_zero
    |=> !in_ready && state == ST_LEN)
    else $error("flush did not start");

  // input is only taken while idle
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE && !cmd.load_out)
    else $error("input ready during flush");
`endif

endmodule

// ----- rtl/core/dqle_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqle_ctrl
// Sequencer: takes characters, then walks a flush of length byte, label
// characters and terminator one beat at a time.
// ----------------------------------------------------------------------------
module dqle_ctrl
  import dqle_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stat_t  stat,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_rst = 1'b1;
        if (in_valid) begin
          if (stat.in_eon) begin
            cmd.ld_eon = 1'b1;
            state_next = stat.count_zero ? ST_TERM : ST_LEN;
          end else if (stat.in_dot) begin
            cmd.ld_eon = 1'b1;
            if (!stat.count_zero) begin
              state_next = ST_LEN;
            end
          end else if (stat.count_full) begin
            cmd.set_trunc = 1'b1;
          end else begin
            cmd.wr_char = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = OSEL_LEN;
          state_next   = ST_CHARS;
        end
      end
      ST_CHARS: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = OSEL_CHAR;
          cmd.out_last = stat.rd_at_end && !stat.eon_flag;
          cmd.rd_adv   = 1'b1;
          if (stat.rd_at_end) begin
            cmd.clr_count = 1'b1;
            state_next    = stat.eon_flag ? ST_TERM : ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        if (stat.slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_sel   = OSEL_TERM;
          cmd.out_last  = 1'b1;
          cmd.clr_trunc = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/dqle_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqle_datapath
// Label store, label count, truncation flag and the output beat register.
// ----------------------------------------------------------------------------
module dqle_datapath
  import dqle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       end_of_name,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       name_end,
  output logic       label_truncated
);

  logic [7:0]       label_mem [LABEL_MAX];
  logic [CNT_W-1:0] count;
  logic             trunc_seen;
  logic             eon_flag;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] rd_idx_next;
  logic [7:0]       rdata;
  logic [7:0]       byte_next;

  // label store: write on held character, registered read one ahead
  always_comb begin
    if (cmd.rd_rst) begin
      rd_idx_next = '0;
    end else if (cmd.rd_adv) begin
      rd_idx_next = rd_idx + IDX_W'(1);
    end else begin
      rd_idx_next = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_char) begin
      label_mem[count[IDX_W-1:0]] <= ch;
    end
    rdata <= label_mem[rd_idx_next];
  end

  // read pointer, count and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      count      <= '0;
      trunc_seen <= 1'b0;
      eon_flag   <= 1'b0;
    end else begin
      rd_idx <= rd_idx_next;
      if (cmd.clr_count) begin
        count <= '0;
      end else if (cmd.wr_char) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.clr_trunc) begin
        trunc_seen <= 1'b0;
      end else if (cmd.set_trunc) begin
        trunc_seen <= 1'b1;
      end
      if (cmd.ld_eon) begin
        eon_flag <= end_of_name;
      end
    end
  end

  // status to controller
  always_comb begin
    stat.in_eon     = end_of_name;
    stat.in_dot     = (ch == DOT_CHAR);
    stat.count_zero = (count == '0);
    stat.count_full = (count == CNT_W'(LABEL_MAX));
    stat.eon_flag   = eon_flag;
    stat.rd_at_end  = (CNT_W'(rd_idx) == count - CNT_W'(1));
    stat.slot_free  = !out_valid || out_ready;
  end

  // output byte select
  always_comb begin
    case (cmd.out_sel)
      OSEL_LEN:  byte_next = 8'(count);
      OSEL_CHAR: byte_next = rdata;
      OSEL_TERM: byte_next = 8'h00;
      default:   byte_next = 8'h00;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte        <= byte_next;
      last            <= cmd.out_last;
      name_end        <= (cmd.out_sel == OSEL_TERM);
      label_truncated <= (cmd.out_sel == OSEL_TERM) && trunc_seen;
    end
  end

endmodule
